FILE: hdl/ray_box_slab_test_assert.svh
// Assertion macros shared by the ray box slab test design.
`ifndef RAY_BOX_SLAB_TEST_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define RBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define RBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rbs_pkg.sv
// Package with shared widths, constants and register indexes of the ray box slab test.
package rbs_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_AXES      = 3;
  localparam int NUM_REGS      = 6;
  localparam int CFG_IDX_W     = 3;

  // Pre-check stage, one stage per quotient bit and a final saturation stage.
  localparam int DIV_LAT = DATA_W + 2;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_t;

endpackage

FILE: hdl/rbs_if.sv
// Channel interfaces for ray items and hit results.
interface rbs_ray_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbs_pkg::DATA_W-1:0]   origin_x;
  logic signed [rbs_pkg::DATA_W-1:0]   origin_y;
  logic signed [rbs_pkg::DATA_W-1:0]   origin_z;
  logic signed [rbs_pkg::DATA_W-1:0]   dir_x;
  logic signed [rbs_pkg::DATA_W-1:0]   dir_y;
  logic signed [rbs_pkg::DATA_W-1:0]   dir_z;
  logic signed [rbs_pkg::DATA_W-1:0]   t_start;
  logic signed [rbs_pkg::DATA_W-1:0]   t_end;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_start, t_end, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_start, t_end, output ready);
endinterface

interface rbs_hit_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [rbs_pkg::DATA_W-1:0]   entry_t;
  logic signed [rbs_pkg::DATA_W-1:0]   exit_t;

  modport source (output valid, hit, entry_t, exit_t, input ready);
  modport sink   (input valid, hit, entry_t, exit_t, output ready);
endinterface

FILE: hdl/rbs_slab_div.sv
// Pipelined saturating signed fixed-point divider, one quotient bit per stage.
module rbs_slab_div #(
  parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rbs_pkg::DATA_W:0]          nm_i,
  input  logic [rbs_pkg::DATA_W-1:0]        dm_i,
  input  logic                              num_neg_i,
  input  logic                              quo_neg_i,
  input  logic                              dz_i,
  output logic signed [rbs_pkg::DATA_W-1:0] quo_o
);

  localparam int DW = rbs_pkg::DATA_W;
  localparam int NW = DW + 1 + FRAC_BITS;

  logic [NW-1:0] dvd;

  logic [DW-1:0] rem_r  [0:DW];
  logic [DW-1:0] low_r  [0:DW];
  logic [DW-1:0] q_r    [0:DW];
  logic [DW-1:0] dm_r   [0:DW];
  logic          ov_r   [0:DW];
  logic          nneg_r [0:DW];
  logic          qneg_r [0:DW];
  logic          dz_r   [0:DW];

  logic signed [DW-1:0] quo_nxt;
  logic signed [DW-1:0] quo_r;

  // Scaled dividend; a quotient of 2**DW or more is flagged up front.
  assign dvd = NW'(nm_i) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DW'(dvd >> DW);
      low_r[0]  <= dvd[DW-1:0];
      q_r[0]    <= '0;
      dm_r[0]   <= dm_i;
      ov_r[0]   <= (dvd >> DW) >= NW'(dm_i);
      nneg_r[0] <= num_neg_i;
      qneg_r[0] <= quo_neg_i;
      dz_r[0]   <= dz_i;
    end
  end

  // Restoring division stages, one quotient bit each.
  for (genvar k = 1; k <= DW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem_r[k-1], low_r[k-1][DW-1]};
    assign ge    = trial >= {1'b0, dm_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? DW'(trial - {1'b0, dm_r[k-1]}) : trial[DW-1:0];
        low_r[k]  <= low_r[k-1] << 1;
        q_r[k]    <= {q_r[k-1][DW-2:0], ge};
        dm_r[k]   <= dm_r[k-1];
        ov_r[k]   <= ov_r[k-1];
        nneg_r[k] <= nneg_r[k-1];
        qneg_r[k] <= qneg_r[k-1];
        dz_r[k]   <= dz_r[k-1];
      end
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    if (dz_r[DW]) begin
      quo_nxt = nneg_r[DW] ? rbs_pkg::S_MIN : rbs_pkg::S_MAX;
    end else if (qneg_r[DW]) begin
      if (ov_r[DW] || (q_r[DW][DW-1] && (|q_r[DW][DW-2:0]))) begin
        quo_nxt = rbs_pkg::S_MIN;
      end else begin
        quo_nxt = $signed(DW'(-q_r[DW]));
      end
    end else if (ov_r[DW] || q_r[DW][DW-1]) begin
      quo_nxt = rbs_pkg::S_MAX;
    end else begin
      quo_nxt = $signed(q_r[DW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo_o = quo_r;

endmodule

FILE: hdl/ray_box_slab_test.sv
// A ray passes the capture, product, operand, divider, ordering, reduction and hit stages, then the output register.
// Throughput: one ray per cycle while the skid stage is empty; 32-stage quotient pipelines set depth, not rate.
// A two-entry output register and skid stage keep input transfers going while a result waits.
// Reset (synchronous, active low) clears all box registers to zero and empties the pipeline.
// A box register write reaches new rays once it has passed into the ordered bound registers.
`include "ray_box_slab_test_assert.svh"

module ray_box_slab_test #(
  parameter int COORD_FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [rbs_pkg::DATA_W-1:0]             cfg_wdata,
  rbs_ray_if.sink                                in_ray,
  rbs_hit_if.source                              out_hit
);

  localparam int DW       = rbs_pkg::DATA_W;
  localparam int NA       = rbs_pkg::NUM_AXES;
  localparam int PW       = 2 * DW;
  localparam int S_DIVIN  = 3;
  localparam int S_INSIDE = 4;
  localparam int S_DIVOUT = S_DIVIN + rbs_pkg::DIV_LAT;
  localparam int S_MINMAX = S_DIVOUT + 1;
  localparam int S_REDUCE = S_MINMAX + 1;
  localparam int S_LAST   = S_REDUCE + 1;

  typedef struct packed {
    logic signed [DW-1:0] ts;
    logic signed [DW-1:0] te;
    logic                 ins_s;
    logic                 ins_e;
  } side_t;

  typedef logic signed [DW-1:0] word_t;

  // Saturate a wide signed value to the word range.
  function automatic word_t sat_word(input logic signed [PW:0] v);
    word_t res;
    if (v > (PW+1)'(rbs_pkg::S_MAX)) begin
      res = rbs_pkg::S_MAX;
    end else if (v < (PW+1)'(rbs_pkg::S_MIN)) begin
      res = rbs_pkg::S_MIN;
    end else begin
      res = word_t'(v);
    end
    return res;
  endfunction

  logic pipe_en;

  // Box registers and their ordered bounds.
  word_t box_r    [0:rbs_pkg::NUM_REGS-1];
  word_t box_lo_r [0:NA-1];
  word_t box_hi_r [0:NA-1];

  logic vld_r [1:S_LAST];

  // Stage 1: captured ray.
  word_t o1_r [0:NA-1];
  word_t d1_r [0:NA-1];
  word_t ts1_r, te1_r;

  // Stage 2: products and slab numerators.
  word_t                o2_r [0:NA-1];
  word_t                d2_r [0:NA-1];
  logic signed [PW-1:0] prs2_r [0:NA-1];
  logic signed [PW-1:0] pre2_r [0:NA-1];
  logic signed [DW:0]   nlo2_r [0:NA-1];
  logic signed [DW:0]   nhi2_r [0:NA-1];
  word_t ts2_r, te2_r;

  // Stage 3: end points and divider operands.
  word_t           pts3_r  [0:NA-1];
  word_t           pte3_r  [0:NA-1];
  logic [DW:0]     mlo3_r  [0:NA-1];
  logic [DW:0]     mhi3_r  [0:NA-1];
  logic [DW-1:0]   dm3_r   [0:NA-1];
  logic            nnlo3_r [0:NA-1];
  logic            nnhi3_r [0:NA-1];
  logic            qnlo3_r [0:NA-1];
  logic            qnhi3_r [0:NA-1];
  logic            dz3_r   [0:NA-1];
  word_t ts3_r, te3_r;

  side_t side_r [S_INSIDE:S_REDUCE];
  side_t side_nxt;

  word_t tq_lo [0:NA-1];
  word_t tq_hi [0:NA-1];
  word_t tmin_r [0:NA-1];
  word_t tmax_r [0:NA-1];
  word_t entry_r, exit_r, entry_nxt, exit_nxt;
  logic  hit_r;
  word_t entry_fin_r, exit_fin_r;

  // Output register and skid stage.
  logic  out_valid_r, skid_valid_r;
  logic  out_hit_r, skid_hit_r;
  word_t out_entry_r, out_exit_r, skid_entry_r, skid_exit_r;
  logic  take;

  assign pipe_en      = !skid_valid_r;
  assign in_ray.ready = pipe_en;

  // Configuration writes; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rbs_pkg::NUM_REGS; i++) begin
        box_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_idx <= rbs_pkg::REG_MAX_Z)) begin
      box_r[cfg_idx] <= $signed(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      box_lo_r[a] <= (box_r[a] < box_r[a+NA]) ? box_r[a] : box_r[a+NA];
      box_hi_r[a] <= (box_r[a] < box_r[a+NA]) ? box_r[a+NA] : box_r[a];
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= S_LAST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (pipe_en) begin
      vld_r[1] <= in_ray.valid;
      for (int k = 2; k <= S_LAST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1: ray capture.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      o1_r[0] <= in_ray.origin_x;
      o1_r[1] <= in_ray.origin_y;
      o1_r[2] <= in_ray.origin_z;
      d1_r[0] <= in_ray.dir_x;
      d1_r[1] <= in_ray.dir_y;
      d1_r[2] <= in_ray.dir_z;
      ts1_r   <= in_ray.t_start;
      te1_r   <= in_ray.t_end;
    end
  end

  // Stage 2: parameter times direction, bound minus origin.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int a = 0; a < NA; a++) begin
        o2_r[a]   <= o1_r[a];
        d2_r[a]   <= d1_r[a];
        prs2_r[a] <= PW'(ts1_r) * PW'(d1_r[a]);
        pre2_r[a] <= PW'(te1_r) * PW'(d1_r[a]);
        nlo2_r[a] <= (DW+1)'(box_lo_r[a]) - (DW+1)'(o1_r[a]);
        nhi2_r[a] <= (DW+1)'(box_hi_r[a]) - (DW+1)'(o1_r[a]);
      end
      ts2_r <= ts1_r;
      te2_r <= te1_r;
    end
  end

  // Stage 3: floor-shifted points with saturation, divider operand magnitudes.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int a = 0; a < NA; a++) begin
        pts3_r[a]  <= sat_word((PW+1)'(sat_word((PW+1)'(prs2_r[a] >>> COORD_FRAC_BITS)))
                               + (PW+1)'(o2_r[a]));
        pte3_r[a]  <= sat_word((PW+1)'(sat_word((PW+1)'(pre2_r[a] >>> COORD_FRAC_BITS)))
                               + (PW+1)'(o2_r[a]));
        mlo3_r[a]  <= nlo2_r[a][DW] ? (DW+1)'(-nlo2_r[a]) : nlo2_r[a];
        mhi3_r[a]  <= nhi2_r[a][DW] ? (DW+1)'(-nhi2_r[a]) : nhi2_r[a];
        dm3_r[a]   <= d2_r[a][DW-1] ? DW'(-d2_r[a]) : d2_r[a];
        nnlo3_r[a] <= nlo2_r[a][DW];
        nnhi3_r[a] <= nhi2_r[a][DW];
        qnlo3_r[a] <= nlo2_r[a][DW] ^ d2_r[a][DW-1];
        qnhi3_r[a] <= nhi2_r[a][DW] ^ d2_r[a][DW-1];
        dz3_r[a]   <= d2_r[a] == '0;
      end
      ts3_r <= ts2_r;
      te3_r <= te2_r;
    end
  end

  // Slab dividers, one for each bound of each axis.
  for (genvar a = 0; a < NA; a++) begin : g_axis
    rbs_slab_div #(.FRAC_BITS(COORD_FRAC_BITS)) u_div_lo (
      .clk       (clk),
      .en        (pipe_en),
      .nm_i      (mlo3_r[a]),
      .dm_i      (dm3_r[a]),
      .num_neg_i (nnlo3_r[a]),
      .quo_neg_i (qnlo3_r[a]),
      .dz_i      (dz3_r[a]),
      .quo_o     (tq_lo[a])
    );

    rbs_slab_div #(.FRAC_BITS(COORD_FRAC_BITS)) u_div_hi (
      .clk       (clk),
      .en        (pipe_en),
      .nm_i      (mhi3_r[a]),
      .dm_i      (dm3_r[a]),
      .num_neg_i (nnhi3_r[a]),
      .quo_neg_i (qnhi3_r[a]),
      .dz_i      (dz3_r[a]),
      .quo_o     (tq_hi[a])
    );
  end

  // Stage 4: containment of both interval end points, then a delay line to the reduction.
  always_comb begin
    side_nxt.ts    = ts3_r;
    side_nxt.te    = te3_r;
    side_nxt.ins_s = 1'b1;
    side_nxt.ins_e = 1'b1;
    for (int a = 0; a < NA; a++) begin
      if (pts3_r[a] < box_lo_r[a] || pts3_r[a] > box_hi_r[a]) begin
        side_nxt.ins_s = 1'b0;
      end
      if (pte3_r[a] < box_lo_r[a] || pte3_r[a] > box_hi_r[a]) begin
        side_nxt.ins_e = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side_r[S_INSIDE] <= side_nxt;
      for (int k = S_INSIDE + 1; k <= S_REDUCE; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Per-axis ordering of the two slab parameters.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int a = 0; a < NA; a++) begin
        tmin_r[a] <= (tq_lo[a] < tq_hi[a]) ? tq_lo[a] : tq_hi[a];
        tmax_r[a] <= (tq_lo[a] < tq_hi[a]) ? tq_hi[a] : tq_lo[a];
      end
    end
  end

  // Entry is the largest minimum, exit the smallest maximum.
  always_comb begin
    entry_nxt = tmin_r[0];
    exit_nxt  = tmax_r[0];
    for (int a = 1; a < NA; a++) begin
      if (tmin_r[a] > entry_nxt) begin
        entry_nxt = tmin_r[a];
      end
      if (tmax_r[a] < exit_nxt) begin
        exit_nxt = tmax_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      entry_r <= entry_nxt;
      exit_r  <= exit_nxt;
    end
  end

  // Final hit decision.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      hit_r       <= side_r[S_REDUCE].ins_s || side_r[S_REDUCE].ins_e ||
                     ((exit_r >= entry_r) && (side_r[S_REDUCE].ts <= exit_r) &&
                      (exit_r <= side_r[S_REDUCE].te));
      entry_fin_r <= entry_r;
      exit_fin_r  <= exit_r;
    end
  end

  // Output register with a skid stage behind it.
  assign take = out_valid_r && out_hit.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_hit_r    <= skid_hit_r;
        out_entry_r  <= skid_entry_r;
        out_exit_r   <= skid_exit_r;
        skid_valid_r <= 1'b0;
      end
    end else if (vld_r[S_LAST]) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
        out_hit_r   <= hit_r;
        out_entry_r <= entry_fin_r;
        out_exit_r  <= exit_fin_r;
      end else begin
        skid_valid_r <= 1'b1;
        skid_hit_r   <= hit_r;
        skid_entry_r <= entry_fin_r;
        skid_exit_r  <= exit_fin_r;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_hit.valid   = out_valid_r;
  assign out_hit.hit     = out_hit_r;
  assign out_hit.entry_t = out_entry_r;
  assign out_hit.exit_t  = out_exit_r;

  // Checks on the output staging.
  `RBS_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid full while output empty")
  `RBS_ASSERT_NXT(a_stall_holds_end, clk, rst_n, !pipe_en, $stable(vld_r[S_LAST]), "pipeline moved while stalled")
  `RBS_ASSERT_IMP(a_skid_fill_cause, clk, rst_n, $rose(skid_valid_r), $past(out_valid_r && !out_hit.ready), "skid filled without a blocked output")

endmodule
